// ----- rtl/ftg_pkg.sv -----
// Package for the Fresnel transfer generator: shared widths, register codes,
// the CORDIC stage record and the arctangent table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ftg_pkg;

    // Field and datapath widths.
    localparam int IDX_W      = 12;
    localparam int DIM_W      = 13;
    localparam int COEF_W     = 32;
    localparam int SQ_W       = 2 * IDX_W;
    localparam int PHASE_W    = 32;
    localparam int XY_W       = 33;
    localparam int ANG_W      = 33;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_COLS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_X      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Y      = 2'd3;

    // Reset values of the registers.
    localparam logic [DIM_W-1:0]  DIM_RESET  = 13'd1024;
    localparam logic [COEF_W-1:0] COEF_RESET = 32'd0;

    // CORDIC constants: gain-corrected 1.0 in Q2.30 and the rounding half (half a Q1.15 step) in Q2.30.
    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [XY_W-1:0] CORDIC_X0 = 33'sd652032874;
    localparam logic signed [XY_W:0]   ROUND_HALF = 34'sd16384;
    localparam logic signed [XY_W-15:0] Q15_POS_MAX = 19'sd32767;
    localparam logic signed [XY_W-15:0] Q15_NEG_MAX = -19'sd32767;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam logic [ANG_W-1:0] ATAN_TURNS [0:ATAN_ENTRIES-1] = '{
        33'd536870912, 33'd316933406, 33'd167458907, 33'd85004756,
        33'd42667331,  33'd21354465,  33'd10679838,  33'd5340245,
        33'd2670163,   33'd1335087,   33'd667544,    33'd333772,
        33'd166886,    33'd83443,     33'd41722,     33'd20861,
        33'd10430,     33'd5215,      33'd2608,      33'd1304,
        33'd652,       33'd326,       33'd163,       33'd81
    };

    // Rotation vector, residual angle and half-turn flag carried between stages.
    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] ang;
        logic                    flip;
    } cordic_t;

endpackage : ftg_pkg

`default_nettype wire

// ----- rtl/fresnel_transfer_generator_core.sv -----
// Top level of the Fresnel transfer generator: configuration registers and
// the pipeline of ftg_phase, ftg_cordic_stage and ftg_round. Depends on ftg_pkg.
//
// Usage: each request on the s_ channel carries a column and row index of the
// frequency grid. The block returns one response on the m_ channel with the
// cosine and sine of the Fresnel chirp phase at that pixel, in Q1.15.
// Both channels use valid/ready; a request is taken when valid and ready are
// both high. The configuration port writes grid size and phase coefficients
// with cfg_wr_en, cfg_wr_index and cfg_wr_data, one register per cycle. The
// user must see that it is written only while no request is in flight; the
// block has no check for this. Throughput: one request per cycle while m_ready
// keeps the output flowing. Stages: four phase stages, one per CORDIC rotation
// and one rounding stage, with min(TRIG_STAGES, 24) rotations, 16 by default.
// Every stage has its own valid bit and moves whenever it is empty or its
// successor takes its request, so bubbles close up and a stalled receiver
// backs the pipeline up without losing or repeating a request.
// Reset clears all valid bits and loads the register defaults: 1024 columns,
// 1024 rows and zero coefficients. s_ready is high right after reset.
`timescale 1ns / 1ps
`default_nettype none

module fresnel_transfer_generator_core #(
    parameter int MAX_COLS    = 4096,
    parameter int MAX_ROWS    = 4096,
    parameter int TRIG_STAGES = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [ftg_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  wire logic [ftg_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [ftg_pkg::IDX_W-1:0]         s_col_index,
    input  wire logic [ftg_pkg::IDX_W-1:0]         s_row_index,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [ftg_pkg::OUT_W-1:0]       m_cos_value,
    output logic signed [ftg_pkg::OUT_W-1:0]       m_sin_value
);
    import ftg_pkg::*;

    localparam int NUM_ROT = (TRIG_STAGES < ATAN_ENTRIES) ? TRIG_STAGES : ATAN_ENTRIES;
    localparam logic [16:0] COLS_LIMIT = 17'(MAX_COLS);
    localparam logic [16:0] ROWS_LIMIT = 17'(MAX_ROWS);

    logic [DIM_W-1:0]   width_cols_reg, height_rows_reg;
    logic [COEF_W-1:0]  coef_x_reg, coef_y_reg;

    logic               rot_valid [0:NUM_ROT];
    logic               rot_ready [0:NUM_ROT];
    cordic_t            rot_data  [0:NUM_ROT];

    // Configuration registers; grid sizes clamp to the largest grid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cols_reg  <= DIM_RESET;
            height_rows_reg <= DIM_RESET;
            coef_x_reg      <= COEF_RESET;
            coef_y_reg      <= COEF_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_WIDTH_COLS: begin
                    if ({4'b0, cfg_wr_data[DIM_W-1:0]} > COLS_LIMIT) begin
                        width_cols_reg <= COLS_LIMIT[DIM_W-1:0];
                    end else begin
                        width_cols_reg <= cfg_wr_data[DIM_W-1:0];
                    end
                end
                REG_HEIGHT_ROWS: begin
                    if ({4'b0, cfg_wr_data[DIM_W-1:0]} > ROWS_LIMIT) begin
                        height_rows_reg <= ROWS_LIMIT[DIM_W-1:0];
                    end else begin
                        height_rows_reg <= cfg_wr_data[DIM_W-1:0];
                    end
                end
                REG_COEF_X: begin
                    coef_x_reg <= cfg_wr_data[COEF_W-1:0];
                end
                REG_COEF_Y: begin
                    coef_y_reg <= cfg_wr_data[COEF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Phase computation and fold into the CORDIC start record.
    ftg_phase u_phase (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .col_index    (s_col_index),
        .row_index    (s_row_index),
        .width_cols   (width_cols_reg),
        .height_rows  (height_rows_reg),
        .coef_x_turns (coef_x_reg),
        .coef_y_turns (coef_y_reg),
        .out_valid    (rot_valid[0]),
        .out_ready    (rot_ready[0]),
        .out_data     (rot_data[0])
    );

    // One registered stage per rotation.
    for (genvar k = 0; k < NUM_ROT; k++) begin : g_rot
        ftg_cordic_stage #(
            .STAGE_IDX (k)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (rot_valid[k]),
            .in_ready  (rot_ready[k]),
            .in_data   (rot_data[k]),
            .out_valid (rot_valid[k+1]),
            .out_ready (rot_ready[k+1]),
            .out_data  (rot_data[k+1])
        );
    end

    // Rounding and result register.
    ftg_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rot_valid[NUM_ROT]),
        .in_ready  (rot_ready[NUM_ROT]),
        .in_data   (rot_data[NUM_ROT]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .cos_value (m_cos_value),
        .sin_value (m_sin_value)
    );

    // An empty result register lets every stage move, so input is open.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while the result register is empty");

    // Saturation keeps both parts inside the symmetric range.
    a_no_min_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cos_value != -16'sd32768) && (m_sin_value != -16'sd32768))
        else $error("result outside the symmetric Q1.15 range");

    // The first cycle after reset shows no response.
    a_empty_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("response present right after reset");

endmodule : fresnel_transfer_generator_core

`default_nettype wire

// ----- rtl/ftg_phase.sv -----
// Phase front end: centre offsets, squares, coefficient products and the
// folded CORDIC start record, in four register stages. Depends on ftg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ftg_phase (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [ftg_pkg::IDX_W-1:0]   col_index,
    input  wire logic [ftg_pkg::IDX_W-1:0]   row_index,
    input  wire logic [ftg_pkg::DIM_W-1:0]   width_cols,
    input  wire logic [ftg_pkg::DIM_W-1:0]   height_rows,
    input  wire logic [ftg_pkg::COEF_W-1:0]  coef_x_turns,
    input  wire logic [ftg_pkg::COEF_W-1:0]  coef_y_turns,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output ftg_pkg::cordic_t                 out_data
);
    import ftg_pkg::*;

    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic                     en1, en2, en3, en4;
    logic [IDX_W-1:0]         adx_reg, ady_reg;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;
    logic [PHASE_W-1:0]       px_reg, py_reg;
    cordic_t                  start_reg;

    logic signed [DIM_W-1:0]  dx, dy;
    logic [IDX_W-1:0]         adx_next, ady_next;
    logic [PHASE_W-1:0]       prodx, prody;
    logic [PHASE_W-1:0]       phase;
    cordic_t                  start_next;

    // Each stage moves when it is empty or its successor takes its request.
    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Signed offsets from the centre, row axis flipped, then magnitudes.
    always_comb begin
        dx = $signed({1'b0, col_index}) - $signed({1'b0, width_cols[DIM_W-1:1]});
        dy = $signed({1'b0, height_rows[DIM_W-1:1]}) - $signed({1'b0, row_index});
        adx_next = dx[DIM_W-1] ? IDX_W'(-dx) : dx[IDX_W-1:0];
        ady_next = dy[DIM_W-1] ? IDX_W'(-dy) : dy[IDX_W-1:0];
    end

    // Only the low 32 bits of each product matter, since the phase wraps.
    assign prodx = coef_x_turns * PHASE_W'(sqx_reg);
    assign prody = coef_y_turns * PHASE_W'(sqy_reg);

    // Negate the sum and fold it into the range of a quarter turn either side of zero.
    always_comb begin
        phase            = PHASE_W'(0) - (px_reg + py_reg);
        start_next.x     = CORDIC_X0;
        start_next.y     = '0;
        start_next.flip  = phase[PHASE_W-1] ^ phase[PHASE_W-2];
        if (start_next.flip) begin
            start_next.ang = ANG_W'($signed({~phase[PHASE_W-1], phase[PHASE_W-2:0]}));
        end else begin
            start_next.ang = ANG_W'($signed(phase));
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // Payload stages.
    always_ff @(posedge aclk) begin
        if (en1) begin
            adx_reg <= adx_next;
            ady_reg <= ady_next;
        end
        if (en2) begin
            sqx_reg <= {{IDX_W{1'b0}}, adx_reg} * {{IDX_W{1'b0}}, adx_reg};
            sqy_reg <= {{IDX_W{1'b0}}, ady_reg} * {{IDX_W{1'b0}}, ady_reg};
        end
        if (en3) begin
            px_reg <= prodx;
            py_reg <= prody;
        end
        if (en4) begin
            start_reg <= start_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = start_reg;

endmodule : ftg_phase

`default_nettype wire

// ----- rtl/ftg_cordic_stage.sv -----
// One registered CORDIC rotation stage with its own valid bit.
// Depends on ftg_pkg for the stage record and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module ftg_cordic_stage #(
    parameter int STAGE_IDX = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ftg_pkg::cordic_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ftg_pkg::cordic_t       out_data
);
    import ftg_pkg::*;

    logic                    valid_reg;
    cordic_t                 data_reg;
    cordic_t                 data_next;
    logic signed [XY_W-1:0]  xs, ys;

    assign in_ready = !valid_reg || out_ready;

    // Rotate toward zero residual angle; arithmetic shifts round down.
    always_comb begin
        xs             = in_data.x >>> STAGE_IDX;
        ys             = in_data.y >>> STAGE_IDX;
        data_next.flip = in_data.flip;
        if (!in_data.ang[ANG_W-1]) begin
            data_next.x   = in_data.x - ys;
            data_next.y   = in_data.y + xs;
            data_next.ang = in_data.ang - $signed(ATAN_TURNS[STAGE_IDX]);
        end else begin
            data_next.x   = in_data.x + ys;
            data_next.y   = in_data.y - xs;
            data_next.ang = in_data.ang + $signed(ATAN_TURNS[STAGE_IDX]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule : ftg_cordic_stage

`default_nettype wire

// ----- rtl/ftg_round.sv -----
// Output stage: rounds Q2.30 to Q1.15, saturates, applies the half-turn flip
// and holds the result register. Depends on ftg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ftg_round (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire ftg_pkg::cordic_t            in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [ftg_pkg::OUT_W-1:0] cos_value,
    output logic signed [ftg_pkg::OUT_W-1:0] sin_value
);
    import ftg_pkg::*;

    logic                     valid_reg;
    logic signed [OUT_W-1:0]  cos_reg, sin_reg;
    logic signed [OUT_W-1:0]  cos_next, sin_next;

    // Round half up and clamp to the symmetric Q1.15 range.
    function automatic logic signed [OUT_W-1:0] to_q15(input logic signed [XY_W-1:0] v);
        logic signed [XY_W:0]    rsum;
        logic signed [XY_W-15:0] q;
        logic signed [OUT_W-1:0] r;
        rsum = $signed({v[XY_W-1], v}) + ROUND_HALF;
        q    = rsum[XY_W:15];
        if (q > Q15_POS_MAX) begin
            r = Q15_POS_MAX[OUT_W-1:0];
        end else if (q < Q15_NEG_MAX) begin
            r = Q15_NEG_MAX[OUT_W-1:0];
        end else begin
            r = q[OUT_W-1:0];
        end
        return r;
    endfunction

    assign in_ready = !valid_reg || out_ready;

    // Negate both parts when the angle was folded by half a turn.
    always_comb begin
        cos_next = to_q15(in_data.x);
        sin_next = to_q15(in_data.y);
        if (in_data.flip) begin
            cos_next = -cos_next;
            sin_next = -sin_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign out_valid = valid_reg;
    assign cos_value = cos_reg;
    assign sin_value = sin_reg;

endmodule : ftg_round

`default_nettype wire
